@@ hw/rtl/dqpi_pkg.sv @@
`timescale 1ns / 1ps

package dqpi_pkg;

  // data path widths
  localparam int DATA_WIDTH     = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int LIMIT_WIDTH    = DATA_WIDTH - 1;
  localparam int GAIN_WIDTH     = 16;
  localparam int ERR_WIDTH      = DATA_WIDTH + 1;
  localparam int PROD_WIDTH     = ERR_WIDTH + GAIN_WIDTH + 1;
  localparam int SCALED_WIDTH   = PROD_WIDTH - GAIN_FRAC_BITS;
  localparam int SUM_WIDTH      = SCALED_WIDTH + 1;

  // configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = GAIN_WIDTH;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_CURRENT_LIMIT = 2'd0,
    REG_VOLTAGE_LIMIT = 2'd1,
    REG_PROP_GAIN     = 2'd2,
    REG_INTEG_GAIN    = 2'd3
  } reg_index_t;

  localparam logic [LIMIT_WIDTH-1:0] CURRENT_LIMIT_RESET = '1;
  localparam logic [LIMIT_WIDTH-1:0] VOLTAGE_LIMIT_RESET = '1;
  localparam logic [GAIN_WIDTH-1:0]  PROP_GAIN_RESET     = GAIN_WIDTH'(1 << GAIN_FRAC_BITS);
  localparam logic [GAIN_WIDTH-1:0]  INTEG_GAIN_RESET    = '0;

  typedef struct packed {
    logic [LIMIT_WIDTH-1:0] current_limit;
    logic [LIMIT_WIDTH-1:0] voltage_limit;
    logic [GAIN_WIDTH-1:0]  prop_gain;
    logic [GAIN_WIDTH-1:0]  integ_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] q_target;
    logic signed [DATA_WIDTH-1:0] d_target;
    logic signed [DATA_WIDTH-1:0] q_measured;
    logic signed [DATA_WIDTH-1:0] d_measured;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] q_voltage;
    logic signed [DATA_WIDTH-1:0] d_voltage;
  } out_item_t;

  // symmetric clamp of a wide sum to +/- lim
  function automatic logic signed [DATA_WIDTH-1:0] clamp_sym(
    input logic signed [SUM_WIDTH-1:0] x,
    input logic [LIMIT_WIDTH-1:0] lim
  );
    logic signed [SUM_WIDTH-1:0] lim_pos;
    logic signed [SUM_WIDTH-1:0] lim_neg;
    logic signed [DATA_WIDTH-1:0] res;
    lim_pos = SUM_WIDTH'($signed({1'b0, lim}));
    lim_neg = -lim_pos;
    if (x > lim_pos) begin
      res = lim_pos[DATA_WIDTH-1:0];
    end else if (x < lim_neg) begin
      res = lim_neg[DATA_WIDTH-1:0];
    end else begin
      res = x[DATA_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/dq_current_pi_controller_core.sv @@
`timescale 1ns / 1ps
// path: an accepted input transaction passes through the input register and then
// the result register; throughput: one transaction per cycle while out_stall is low;
// both channels' multiply-add-clamp paths are combinational between the two registers
// reset: clears pipeline valids, integrators and last voltages, and loads the
// default limits and gains

module dq_current_pi_controller_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  dqpi_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output dqpi_pkg::out_item_t                   out_data,
  input  logic                                  cfg_write,
  input  logic [dqpi_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [dqpi_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  dqpi_pkg::cfg_t                         cfg;
  dqpi_pkg::in_item_t                     in_reg;
  dqpi_pkg::out_item_t                    result;
  logic signed [dqpi_pkg::DATA_WIDTH-1:0] q_voltage;
  logic signed [dqpi_pkg::DATA_WIDTH-1:0] d_voltage;
  logic                                   in_reg_valid;
  logic                                   advance;
  logic                                   accept;

  dqpi_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake: move to the result register when it is free or being drained
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= in_data;
    end
  end

  dqpi_channel u_q_channel (
    .clk      (clk),
    .rst      (rst),
    .update   (advance),
    .cfg      (cfg),
    .target   (in_reg.q_target),
    .measured (in_reg.q_measured),
    .voltage  (q_voltage)
  );

  dqpi_channel u_d_channel (
    .clk      (clk),
    .rst      (rst),
    .update   (advance),
    .cfg      (cfg),
    .target   (in_reg.d_target),
    .measured (in_reg.d_measured),
    .voltage  (d_voltage)
  );

  // pack both channel commands
  assign result = {q_voltage, d_voltage};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register empty after a transaction moved in");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_blocked_input_kept: assert property (@(posedge clk) disable iff (rst)
    (in_reg_valid && !advance) |=> in_reg_valid && $stable(in_reg))
    else $error("blocked input transaction lost or changed");
`endif

endmodule

@@ hw/rtl/dqpi_config.sv @@
`timescale 1ns / 1ps

module dqpi_config (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [dqpi_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [dqpi_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  output dqpi_pkg::cfg_t                        cfg
);

  // register file, extra data bits dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_limit <= dqpi_pkg::CURRENT_LIMIT_RESET;
      cfg.voltage_limit <= dqpi_pkg::VOLTAGE_LIMIT_RESET;
      cfg.prop_gain     <= dqpi_pkg::PROP_GAIN_RESET;
      cfg.integ_gain    <= dqpi_pkg::INTEG_GAIN_RESET;
    end else if (cfg_write) begin
      case (dqpi_pkg::reg_index_t'(cfg_index))
        dqpi_pkg::REG_CURRENT_LIMIT: begin
          cfg.current_limit <= cfg_data[dqpi_pkg::LIMIT_WIDTH-1:0];
        end
        dqpi_pkg::REG_VOLTAGE_LIMIT: begin
          cfg.voltage_limit <= cfg_data[dqpi_pkg::LIMIT_WIDTH-1:0];
        end
        dqpi_pkg::REG_PROP_GAIN: begin
          cfg.prop_gain <= cfg_data[dqpi_pkg::GAIN_WIDTH-1:0];
        end
        dqpi_pkg::REG_INTEG_GAIN: begin
          cfg.integ_gain <= cfg_data[dqpi_pkg::GAIN_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/dqpi_channel.sv @@
`timescale 1ns / 1ps

module dqpi_channel (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   update,
  input  dqpi_pkg::cfg_t                         cfg,
  input  logic signed [dqpi_pkg::DATA_WIDTH-1:0] target,
  input  logic signed [dqpi_pkg::DATA_WIDTH-1:0] measured,
  output logic signed [dqpi_pkg::DATA_WIDTH-1:0] voltage
);

  logic signed [dqpi_pkg::DATA_WIDTH-1:0]   integrator;
  logic signed [dqpi_pkg::DATA_WIDTH-1:0]   integrator_next;
  logic signed [dqpi_pkg::DATA_WIDTH-1:0]   last_voltage;
  logic signed [dqpi_pkg::DATA_WIDTH-1:0]   target_clamped;
  logic signed [dqpi_pkg::DATA_WIDTH-1:0]   vlim;
  logic signed [dqpi_pkg::ERR_WIDTH-1:0]    err;
  logic signed [dqpi_pkg::PROD_WIDTH-1:0]   prop_prod;
  logic signed [dqpi_pkg::PROD_WIDTH-1:0]   integ_prod;
  logic signed [dqpi_pkg::SCALED_WIDTH-1:0] prop_term;
  logic signed [dqpi_pkg::SCALED_WIDTH-1:0] integ_term;
  logic signed [dqpi_pkg::SUM_WIDTH-1:0]    integ_sum;
  logic signed [dqpi_pkg::SUM_WIDTH-1:0]    out_sum;
  logic                                     hold;

  // target clamp and exact error
  assign target_clamped = dqpi_pkg::clamp_sym(dqpi_pkg::SUM_WIDTH'(target), cfg.current_limit);
  assign err = dqpi_pkg::ERR_WIDTH'(target_clamped) - dqpi_pkg::ERR_WIDTH'(measured);

  // gain products, arithmetic shift floors toward minus infinity
  assign prop_prod  = dqpi_pkg::PROD_WIDTH'(err)
                    * dqpi_pkg::PROD_WIDTH'($signed({1'b0, cfg.prop_gain}));
  assign integ_prod = dqpi_pkg::PROD_WIDTH'(err)
                    * dqpi_pkg::PROD_WIDTH'($signed({1'b0, cfg.integ_gain}));
  assign prop_term  = dqpi_pkg::SCALED_WIDTH'(prop_prod >>> dqpi_pkg::GAIN_FRAC_BITS);
  assign integ_term = dqpi_pkg::SCALED_WIDTH'(integ_prod >>> dqpi_pkg::GAIN_FRAC_BITS);

  // anti-windup: skip integration while pushing further into saturation
  assign vlim = $signed({1'b0, cfg.voltage_limit});
  assign hold = ((last_voltage >= vlim) && (err > 0))
             || ((last_voltage <= -vlim) && (err < 0));

  // integrator and output clamps
  always_comb begin
    integ_sum = dqpi_pkg::SUM_WIDTH'(integrator);
    if (!hold) begin
      integ_sum = dqpi_pkg::SUM_WIDTH'(integrator) + dqpi_pkg::SUM_WIDTH'(integ_term);
    end
    integrator_next = dqpi_pkg::clamp_sym(integ_sum, cfg.voltage_limit);
    out_sum = dqpi_pkg::SUM_WIDTH'(prop_term) + dqpi_pkg::SUM_WIDTH'(integrator_next);
    voltage = dqpi_pkg::clamp_sym(out_sum, cfg.voltage_limit);
  end

  // channel state, advanced once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator   <= '0;
      last_voltage <= '0;
    end else if (update) begin
      integrator   <= integrator_next;
      last_voltage <= voltage;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_in_limit: assert property (@(posedge clk) disable iff (rst)
    update |=> (last_voltage <= $past(vlim)) && (last_voltage >= -$past(vlim)))
    else $error("voltage command outside voltage limit");

  a_integ_in_limit: assert property (@(posedge clk) disable iff (rst)
    update |=> (integrator <= $past(vlim)) && (integrator >= -$past(vlim)))
    else $error("integrator outside voltage limit");

  a_state_held: assert property (@(posedge clk) disable iff (rst)
    !update |=> $stable(integrator) && $stable(last_voltage))
    else $error("channel state changed without a transaction");
`endif

endmodule
